>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker of the handle pool.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HPFL_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define HPFL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/hpfl_pkg.sv
// ----------------------------------------------------------------------------
// hpfl_pkg
// Types and constants of the handle pool free list.
// ----------------------------------------------------------------------------
package hpfl_pkg;

  localparam int HandleW      = 8;
  localparam int PoolSizeW    = 9;
  localparam int ActionW      = 3;
  localparam int HandleSpace  = 256;
  localparam int MaxHandlesDf = 256;

  localparam logic [ActionW-1:0] ActInit       = 3'd0;
  localparam logic [ActionW-1:0] ActAcquire    = 3'd1;
  localparam logic [ActionW-1:0] ActRelease    = 3'd2;
  localparam logic [ActionW-1:0] ActReleaseAll = 3'd3;
  localparam logic [ActionW-1:0] ActQuery      = 3'd4;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusEmpty    = 2'd1,
    StatusNotInUse = 2'd2,
    StatusInitDone = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SInit,
    SAcq,
    SRelScan,
    SRelCmp,
    SRelShift,
    SRelMove,
    SRelAll,
    SRelAllMove,
    SResp
  } state_e;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [HandleW-1:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [HandleW-1:0] granted_handle;
    status_e            status;
    logic               managed;
  } out_word_t;

endpackage

>>> sv/handle_pool_free_list_unit.sv
// ----------------------------------------------------------------------------
// handle_pool_free_list_unit
// Pool of numbered handles kept as a free stack and an ordered in-use list.
// ----------------------------------------------------------------------------
// Usage:
//   Write pool_size on cfg_we_i/cfg_wdata_i while the block is idle. Send one
//   command word (action, handle) on in_valid_i/in_stall_o; each command gives
//   exactly one result word (granted_handle, status, managed) on
//   out_valid_o/out_stall_i.
//   Commands are taken one at a time; in_stall_o is high from the cycle after
//   an accept until the result enters the output register. The free stack and
//   the in-use list sit in two RAMs with one write and one registered read
//   port each, so every list step costs a RAM access. A query, a failed
//   init, a failed acquire and an unknown action answer without a list
//   step; an acquire reads the top of the free stack and pushes it onto the
//   in-use list; an init writes one handle per step; a release scans the
//   in-use list for the handle and shifts the entries behind it down; a
//   release all moves each in-use handle back onto the free stack.
//   An accept is taken while the previous result still waits in the output
//   register; a stalled receiver holds the result there and the next result
//   waits in the sequencer until the register frees up.
//   Reset empties both lists, clears the created count and pool_size; the RAM
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module handle_pool_free_list_unit #(
  parameter int MaxHandles = hpfl_pkg::MaxHandlesDf
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hpfl_pkg::PoolSizeW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hpfl_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hpfl_pkg::out_word_t            out_word_o
);

  localparam int AW = $clog2(MaxHandles);

  logic [hpfl_pkg::PoolSizeW-1:0] pool_size_q;

  logic                         res_valid;
  hpfl_pkg::out_word_t          res_word;
  logic                         res_ready;

  logic                         free_we;
  logic [AW-1:0]                free_waddr;
  logic [hpfl_pkg::HandleW-1:0] free_wdata;
  logic [AW-1:0]                free_raddr;
  logic [hpfl_pkg::HandleW-1:0] free_rdata;
  logic                         busy_we;
  logic [AW-1:0]                busy_waddr;
  logic [hpfl_pkg::HandleW-1:0] busy_wdata;
  logic [AW-1:0]                busy_raddr;
  logic [hpfl_pkg::HandleW-1:0] busy_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= '0;
    end else if (cfg_we_i) begin
      pool_size_q <= cfg_wdata_i;
    end
  end

  hpfl_ctrl #(
    .MaxHandles(MaxHandles)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pool_size_i (pool_size_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .res_ready_i (res_ready),
    .free_we_o   (free_we),
    .free_waddr_o(free_waddr),
    .free_wdata_o(free_wdata),
    .free_raddr_o(free_raddr),
    .free_rdata_i(free_rdata),
    .busy_we_o   (busy_we),
    .busy_waddr_o(busy_waddr),
    .busy_wdata_o(busy_wdata),
    .busy_raddr_o(busy_raddr),
    .busy_rdata_i(busy_rdata)
  );

  hpfl_ram #(
    .Depth(MaxHandles)
  ) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (free_we),
    .waddr_i(free_waddr),
    .wdata_i(free_wdata),
    .raddr_i(free_raddr),
    .rdata_o(free_rdata)
  );

  hpfl_ram #(
    .Depth(MaxHandles)
  ) u_busy_ram (
    .clk_i  (clk_i),
    .we_i   (busy_we),
    .waddr_i(busy_waddr),
    .wdata_i(busy_wdata),
    .raddr_i(busy_raddr),
    .rdata_o(busy_rdata)
  );

  hpfl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_valid_i(res_valid),
    .load_word_i (res_word),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> sv/hpfl_ram.sv
// ----------------------------------------------------------------------------
// hpfl_ram
// Single-write, single-read synchronous RAM of handles, registered read.
// ----------------------------------------------------------------------------
module hpfl_ram #(
  parameter int Depth = hpfl_pkg::MaxHandlesDf
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(Depth)-1:0]     waddr_i,
  input  logic [hpfl_pkg::HandleW-1:0] wdata_i,
  input  logic [$clog2(Depth)-1:0]     raddr_i,
  output logic [hpfl_pkg::HandleW-1:0] rdata_o
);

  logic [hpfl_pkg::HandleW-1:0] mem [Depth];
  logic [hpfl_pkg::HandleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/hpfl_obuf.sv
// ----------------------------------------------------------------------------
// hpfl_obuf
// Output register: holds one result word for the receiver.
// ----------------------------------------------------------------------------
module hpfl_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_valid_i,
  input  hpfl_pkg::out_word_t load_word_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hpfl_pkg::out_word_t out_word_o
);

  logic                valid_q, valid_d;
  hpfl_pkg::out_word_t word_q;
  logic                load;

  assign ready_o = !valid_q || !out_stall_i;
  assign load    = load_valid_i && ready_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= load_word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> sv/hpfl_ctrl.sv
// ----------------------------------------------------------------------------
// hpfl_ctrl
// Sequencer of the pool: counts, list walks and read-modify-write of the RAMs.
// ----------------------------------------------------------------------------
module hpfl_ctrl #(
  parameter int MaxHandles = hpfl_pkg::MaxHandlesDf,
  localparam int AW        = $clog2(MaxHandles),
  localparam int CW        = $clog2(MaxHandles + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [hpfl_pkg::PoolSizeW-1:0]   pool_size_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  hpfl_pkg::in_word_t               in_word_i,
  output logic                             res_valid_o,
  output hpfl_pkg::out_word_t              res_word_o,
  input  logic                             res_ready_i,
  output logic                             free_we_o,
  output logic [AW-1:0]                    free_waddr_o,
  output logic [hpfl_pkg::HandleW-1:0]     free_wdata_o,
  output logic [AW-1:0]                    free_raddr_o,
  input  logic [hpfl_pkg::HandleW-1:0]     free_rdata_i,
  output logic                             busy_we_o,
  output logic [AW-1:0]                    busy_waddr_o,
  output logic [hpfl_pkg::HandleW-1:0]     busy_wdata_o,
  output logic [AW-1:0]                    busy_raddr_o,
  input  logic [hpfl_pkg::HandleW-1:0]     busy_rdata_i
);

  localparam int LW = (CW > hpfl_pkg::PoolSizeW) ? CW : hpfl_pkg::PoolSizeW;
  localparam int QW = (CW > hpfl_pkg::HandleW) ? CW : hpfl_pkg::HandleW;

  hpfl_pkg::state_e             state_q, state_d;
  logic [CW-1:0]                free_cnt_q, free_cnt_d;
  logic [CW-1:0]                busy_cnt_q, busy_cnt_d;
  logic [CW-1:0]                created_q, created_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [hpfl_pkg::HandleW-1:0] handle_q, handle_d;
  hpfl_pkg::out_word_t          res_q, res_d;

  logic [LW-1:0] lim_a;
  logic [LW-1:0] lim_b;
  logic [CW-1:0] init_n;
  logic [CW-1:0] idx_nx;
  logic          lists_busy;
  logic          acq_fail;
  logic          free_room;
  logic          is_managed;

  always_comb begin
    lim_a = (LW'(pool_size_i) > LW'(MaxHandles)) ? LW'(MaxHandles) : LW'(pool_size_i);
    lim_b = (lim_a > LW'(hpfl_pkg::HandleSpace)) ? LW'(hpfl_pkg::HandleSpace) : lim_a;
  end

  assign init_n     = lim_b[CW-1:0];
  assign idx_nx     = idx_q + CW'(1);
  assign lists_busy = (free_cnt_q != '0) || (busy_cnt_q != '0);
  assign acq_fail   = (free_cnt_q == '0) || (busy_cnt_q >= CW'(MaxHandles));
  assign free_room  = free_cnt_q < CW'(MaxHandles);
  assign is_managed = QW'(in_word_i.handle) < QW'(created_q);

  assign in_stall_o  = state_q != hpfl_pkg::SIdle;
  assign res_valid_o = state_q == hpfl_pkg::SResp;
  assign res_word_o  = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      hpfl_pkg::SIdle: begin
        if (in_valid_i) begin
          case (in_word_i.action)
            hpfl_pkg::ActInit:       state_d = lists_busy ? hpfl_pkg::SResp : hpfl_pkg::SInit;
            hpfl_pkg::ActAcquire:    state_d = acq_fail ? hpfl_pkg::SResp : hpfl_pkg::SAcq;
            hpfl_pkg::ActRelease:    state_d = hpfl_pkg::SRelScan;
            hpfl_pkg::ActReleaseAll: state_d = hpfl_pkg::SRelAll;
            default:                 state_d = hpfl_pkg::SResp;
          endcase
        end
      end
      hpfl_pkg::SInit:     state_d = (idx_q < init_n) ? hpfl_pkg::SInit : hpfl_pkg::SResp;
      hpfl_pkg::SAcq:      state_d = hpfl_pkg::SResp;
      hpfl_pkg::SRelScan:  state_d = (idx_q == busy_cnt_q) ? hpfl_pkg::SResp : hpfl_pkg::SRelCmp;
      hpfl_pkg::SRelCmp: begin
        state_d = (busy_rdata_i == handle_q) ? hpfl_pkg::SRelShift : hpfl_pkg::SRelScan;
      end
      hpfl_pkg::SRelShift: begin
        state_d = (idx_nx < busy_cnt_q) ? hpfl_pkg::SRelMove : hpfl_pkg::SResp;
      end
      hpfl_pkg::SRelMove:    state_d = hpfl_pkg::SRelShift;
      hpfl_pkg::SRelAll:     state_d = (busy_cnt_q == '0) ? hpfl_pkg::SResp : hpfl_pkg::SRelAllMove;
      hpfl_pkg::SRelAllMove: state_d = hpfl_pkg::SRelAll;
      hpfl_pkg::SResp:       state_d = res_ready_i ? hpfl_pkg::SIdle : hpfl_pkg::SResp;
      default:               state_d = hpfl_pkg::SIdle;
    endcase
  end

  always_comb begin
    free_cnt_d   = free_cnt_q;
    busy_cnt_d   = busy_cnt_q;
    created_d    = created_q;
    idx_d        = idx_q;
    handle_d     = handle_q;
    res_d        = res_q;
    free_we_o    = 1'b0;
    free_waddr_o = free_cnt_q[AW-1:0];
    free_wdata_o = handle_q;
    free_raddr_o = AW'(free_cnt_q - CW'(1));
    busy_we_o    = 1'b0;
    busy_waddr_o = busy_cnt_q[AW-1:0];
    busy_wdata_o = free_rdata_i;
    busy_raddr_o = idx_q[AW-1:0];
    case (state_q)
      hpfl_pkg::SIdle: begin
        if (in_valid_i) begin
          handle_d = in_word_i.handle;
          idx_d    = '0;
          res_d    = '0;
          case (in_word_i.action)
            hpfl_pkg::ActInit: begin
              if (lists_busy) begin
                res_d.status = hpfl_pkg::StatusInitDone;
              end
            end
            hpfl_pkg::ActAcquire: begin
              if (acq_fail) begin
                res_d.status = hpfl_pkg::StatusEmpty;
              end
            end
            hpfl_pkg::ActQuery: res_d.managed = is_managed;
            default: ;
          endcase
        end
      end
      hpfl_pkg::SInit: begin
        if (idx_q < init_n) begin
          free_we_o    = 1'b1;
          free_waddr_o = idx_q[AW-1:0];
          free_wdata_o = hpfl_pkg::HandleW'(idx_q);
          idx_d        = idx_nx;
        end else begin
          free_cnt_d = init_n;
          if (init_n > created_q) begin
            created_d = init_n;
          end
        end
      end
      hpfl_pkg::SAcq: begin
        busy_we_o            = 1'b1;
        free_cnt_d           = free_cnt_q - CW'(1);
        busy_cnt_d           = busy_cnt_q + CW'(1);
        res_d.granted_handle = free_rdata_i;
      end
      hpfl_pkg::SRelScan: begin
        if (idx_q == busy_cnt_q) begin
          res_d.status = hpfl_pkg::StatusNotInUse;
        end
      end
      hpfl_pkg::SRelCmp: begin
        if (busy_rdata_i != handle_q) begin
          idx_d = idx_nx;
        end
      end
      hpfl_pkg::SRelShift: begin
        busy_raddr_o = idx_nx[AW-1:0];
        if (!(idx_nx < busy_cnt_q)) begin
          busy_cnt_d = busy_cnt_q - CW'(1);
          if (free_room) begin
            free_we_o  = 1'b1;
            free_cnt_d = free_cnt_q + CW'(1);
          end
        end
      end
      hpfl_pkg::SRelMove: begin
        busy_we_o    = 1'b1;
        busy_waddr_o = idx_q[AW-1:0];
        busy_wdata_o = busy_rdata_i;
        idx_d        = idx_nx;
      end
      hpfl_pkg::SRelAll: begin
        busy_raddr_o = AW'(busy_cnt_q - CW'(1));
      end
      hpfl_pkg::SRelAllMove: begin
        busy_cnt_d   = busy_cnt_q - CW'(1);
        free_wdata_o = busy_rdata_i;
        if (free_room) begin
          free_we_o  = 1'b1;
          free_cnt_d = free_cnt_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hpfl_pkg::SIdle;
      free_cnt_q <= '0;
      busy_cnt_q <= '0;
      created_q  <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
      busy_cnt_q <= busy_cnt_d;
      created_q  <= created_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    res_q    <= res_d;
  end

endmodule

>>> sv/hpfl_checker.sv
// ----------------------------------------------------------------------------
// hpfl_checker
// Port-level checks of the handle pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpfl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hpfl_pkg::out_word_t out_word_o
);

  logic in_acc;
  logic out_held;
  logic out_fail;
  logic fail_clean;
  logic out_managed;
  logic managed_clean;

  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_held      = out_valid_o && out_stall_i;
  assign out_fail      = out_valid_o && (out_word_o.status != hpfl_pkg::StatusOk);
  assign fail_clean    = (out_word_o.granted_handle == '0) && !out_word_o.managed;
  assign out_managed   = out_valid_o && out_word_o.managed;
  assign managed_clean = (out_word_o.status == hpfl_pkg::StatusOk) &&
                         (out_word_o.granted_handle == '0);

  `HPFL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word_o))
  `HPFL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)
  `HPFL_ASSERT_NOW(a_empty_no_grant, clk_i, rst_ni, out_fail, fail_clean)
  `HPFL_ASSERT_NOW(a_managed_only_ok, clk_i, rst_ni, out_managed, managed_clean)

endmodule

bind handle_pool_free_list_unit hpfl_checker u_hpfl_checker (.*);
